// File: rtl/core/ms_pkg.sv
// ----------------------------------------------------------------------------
// ms_pkg
// shared constants, types and controller/datapath command and status
// structs of the merge sorter
// ----------------------------------------------------------------------------
package ms_pkg;

  localparam int MAX_ELEMS = 64;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = $clog2(MAX_ELEMS);
  localparam int CNT_W     = ADDR_W + 1;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  typedef struct packed {
    logic load;
    logic prime;
    logic merge;
    logic emit_start;
    logic emit_step;
    logic clear;
  } ms_cmd_t;

  typedef struct packed {
    logic more_pass;
    logic pass_done;
    logic emit_last;
  } ms_stat_t;

endpackage

// File: rtl/core/ms_channels.sv
// ----------------------------------------------------------------------------
// ms_channels
// valid/ready stream interfaces for the element input and the sorted output
// ----------------------------------------------------------------------------
interface ms_in_if import ms_pkg::*;;
  logic  valid;
  logic  ready;
  data_t value;
  logic  last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface ms_out_if import ms_pkg::*;;
  logic  valid;
  logic  ready;
  data_t sorted_value;
  logic  end_of_set;
  logic  overflow;

  modport source (output valid, output sorted_value, output end_of_set, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_value, input end_of_set, input overflow,
                  output ready);
endinterface

// File: rtl/core/ms_ram.sv
// ----------------------------------------------------------------------------
// ms_ram
// element buffer: one write port, two read ports with registered read data
// ----------------------------------------------------------------------------
module ms_ram
  import ms_pkg::*;
(
  input  logic  clk,
  input  logic  we,
  input  addr_t waddr,
  input  data_t wdata,
  input  addr_t raddr_a,
  input  addr_t raddr_b,
  output data_t rdata_a,
  output data_t rdata_b
);

  data_t mem [MAX_ELEMS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: rtl/core/ms_datapath.sv
// ----------------------------------------------------------------------------
// ms_datapath
// ping-pong element buffers, merge pointers and compare, run bookkeeping,
// element count, drop flag and output read pointer
// ----------------------------------------------------------------------------
module ms_datapath
  import ms_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  ms_cmd_t  cmd,
  input  data_t    value,
  output ms_stat_t stat,
  output data_t    sorted_value,
  output logic     end_of_set,
  output logic     overflow
);

  cnt_t  count, count_next;
  logic  dropped, dropped_next;
  cnt_t  width, width_next;
  logic  src, src_next;
  cnt_t  i, i_next, j, j_next, mid, mid_next, hi, hi_next, k, k_next;
  cnt_t  ptr, ptr_next;

  logic  we0, we1;
  addr_t waddr, raddr_a, raddr_b;
  data_t wdata, rd0_a, rd0_b, rd1_a, rd1_b, head_a, head_b;
  logic  take_left;

  function automatic cnt_t clip(input logic [CNT_W:0] x, input cnt_t n);
    cnt_t r;
    r = (x > {1'b0, n}) ? n : x[CNT_W-1:0];
    return r;
  endfunction

  assign head_a    = src ? rd1_a : rd0_a;
  assign head_b    = src ? rd1_b : rd0_b;
  assign take_left = (i < mid) && ((j >= hi) || (head_a <= head_b));

  always_comb begin
    count_next   = count;
    dropped_next = dropped;
    width_next   = width;
    src_next     = src;
    i_next       = i;
    j_next       = j;
    mid_next     = mid;
    hi_next      = hi;
    k_next       = k;
    ptr_next     = ptr;

    if (cmd.load) begin
      if (count < cnt_t'(MAX_ELEMS)) begin
        count_next = count + 1'b1;
      end else begin
        dropped_next = 1'b1;
      end
    end

    if (cmd.prime) begin
      i_next   = '0;
      mid_next = clip({1'b0, width}, count);
      j_next   = mid_next;
      hi_next  = clip({width, 1'b0}, count);
      k_next   = '0;
    end

    if (cmd.merge) begin
      k_next = k + 1'b1;
      if (k_next == hi) begin
        i_next   = hi;
        mid_next = clip({1'b0, hi} + {1'b0, width}, count);
        j_next   = mid_next;
        hi_next  = clip({1'b0, hi} + {width, 1'b0}, count);
      end else if (take_left) begin
        i_next = i + 1'b1;
      end else begin
        j_next = j + 1'b1;
      end
      if (k_next == count) begin
        width_next = {width[CNT_W-2:0], 1'b0};
        src_next   = ~src;
      end
    end

    if (cmd.emit_start) begin
      ptr_next = '0;
    end else if (cmd.emit_step) begin
      ptr_next = ptr + 1'b1;
    end

    if (cmd.clear) begin
      count_next   = '0;
      dropped_next = 1'b0;
      width_next   = cnt_t'(1);
      src_next     = 1'b0;
    end
  end

  // write side: loads go to bank 0, merges go to the bank not being read
  assign we0   = cmd.load ? (count < cnt_t'(MAX_ELEMS)) : (cmd.merge && src);
  assign we1   = cmd.merge && !src;
  assign waddr = cmd.load ? count[ADDR_W-1:0] : k[ADDR_W-1:0];
  assign wdata = cmd.load ? value : (take_left ? head_a : head_b);

  assign raddr_a = (cmd.emit_start || cmd.emit_step || !cmd.merge && !cmd.prime)
                   ? ptr_next[ADDR_W-1:0] : i_next[ADDR_W-1:0];
  assign raddr_b = j_next[ADDR_W-1:0];

  ms_ram u_bank0 (
    .clk     (clk),
    .we      (we0),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd0_a),
    .rdata_b (rd0_b)
  );

  ms_ram u_bank1 (
    .clk     (clk),
    .we      (we1),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd1_a),
    .rdata_b (rd1_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      dropped <= 1'b0;
      width   <= cnt_t'(1);
      src     <= 1'b0;
    end else begin
      count   <= count_next;
      dropped <= dropped_next;
      width   <= width_next;
      src     <= src_next;
    end
    i   <= i_next;
    j   <= j_next;
    mid <= mid_next;
    hi  <= hi_next;
    k   <= k_next;
    ptr <= ptr_next;
  end

  assign stat.more_pass = width < count;
  assign stat.pass_done = cmd.merge && (k + 1'b1 == count);
  assign stat.emit_last = (ptr + 1'b1 == count);

  assign sorted_value = head_a;
  assign end_of_set   = stat.emit_last;
  assign overflow     = dropped;

endmodule

// File: rtl/core/ms_ctrl.sv
// ----------------------------------------------------------------------------
// ms_ctrl
// sequencer: load, merge pass priming, merge steps and output of the set
// ----------------------------------------------------------------------------
module ms_ctrl
  import ms_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_last,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  ms_stat_t stat,
  output ms_cmd_t  cmd
);

  typedef enum logic [1:0] {LOAD, PRIME, MERGE, EMIT} state_t;

  state_t state;

  assign in_ready = (state == LOAD);

  always_comb begin
    cmd            = '0;
    cmd.load       = (state == LOAD) && in_valid;
    cmd.prime      = (state == PRIME) && stat.more_pass;
    cmd.emit_start = (state == PRIME) && !stat.more_pass;
    cmd.merge      = (state == MERGE);
    cmd.emit_step  = (state == EMIT) && out_ready;
    cmd.clear      = cmd.emit_step && stat.emit_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= LOAD;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        LOAD: begin
          if (in_valid && in_last) begin
            state <= PRIME;
          end
        end
        PRIME: begin
          if (stat.more_pass) begin
            state <= MERGE;
          end else begin
            state     <= EMIT;
            out_valid <= 1'b1;
          end
        end
        MERGE: begin
          if (stat.pass_done) begin
            state <= PRIME;
          end
        end
        EMIT: begin
          if (out_ready && stat.emit_last) begin
            state     <= LOAD;
            out_valid <= 1'b0;
          end
        end
        default: begin
          state     <= LOAD;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/merge_sorter_top.sv
// ----------------------------------------------------------------------------
// merge_sorter_top
// collects a set of signed 32-bit elements and returns it in ascending order
//
// elements: one value per transfer; the transfer with last high closes the set.
// up to 64 elements are kept, later ones are dropped and flagged as overflow.
// sorted: one value per transfer in ascending order, end_of_set on the final
// one, overflow the same on every transfer of a set.
// the sort runs ceil(log2 n) merge passes, each a prime step and then merge
// steps, one output element per cycle through the compare and the buffer's
// write port. once no further pass is due, the first sorted transfer is
// offered, then one per cycle while the receiver is ready.
// elements is not ready while a set is being sorted or emitted.
// when the receiver stalls, the current sorted transfer holds.
// reset (synchronous) empties the set and returns to loading.
// ----------------------------------------------------------------------------
module merge_sorter_top
  import ms_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  ms_in_if.sink     elements,
  ms_out_if.source  sorted
);

  ms_cmd_t  cmd;
  ms_stat_t stat;

  ms_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (elements.valid),
    .in_last   (elements.last),
    .in_ready  (elements.ready),
    .out_valid (sorted.valid),
    .out_ready (sorted.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ms_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .value        (elements.value),
    .stat         (stat),
    .sorted_value (sorted.sorted_value),
    .end_of_set   (sorted.end_of_set),
    .overflow     (sorted.overflow)
  );

endmodule

// File: dv/merge_sorter_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// merge_sorter_checker
// watches the element and sorted channels of the merge sorter, keeps its own
// copy of the set being loaded, sorts it by bottom-up merge passes when the
// closing transfer arrives and compares every sorted transfer field by field
// ----------------------------------------------------------------------------
module merge_sorter_checker
  import ms_pkg::*;
(
  input  logic clk,
  input  logic rst,
  ms_in_if     elements,
  ms_out_if    sorted,
  output int   mismatches,
  output int   results_due
);

  typedef struct packed {
    data_t value;
    logic  end_of_set;
    logic  overflow;
  } sorted_item_t;

  sorted_item_t sorted_due[$];
  data_t        set_buf[MAX_ELEMS];
  data_t        merge_buf[MAX_ELEMS];
  int           fill_count;
  logic         set_dropped;

  initial begin
    mismatches  = 0;
    results_due = 0;
  end

  task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                 logic [DATA_W-1:0] want);
    $display("checker: %s got %h want %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    sorted_item_t want;
    int           w, lo, mid, hi, i, j, k;
    if (rst) begin
      fill_count  = 0;
      set_dropped = 1'b0;
      sorted_due.delete();
    end else begin
      if (sorted.valid && sorted.ready) begin
        if (sorted_due.size() == 0) begin
          report_mismatch("sorted transfer with nothing pending", sorted.sorted_value, '0);
        end else begin
          want = sorted_due.pop_front();
          if (sorted.sorted_value !== want.value)
            report_mismatch("sorted_value", sorted.sorted_value, want.value);
          if (sorted.end_of_set !== want.end_of_set)
            report_mismatch("end_of_set", DATA_W'(sorted.end_of_set),
                            DATA_W'(want.end_of_set));
          if (sorted.overflow !== want.overflow)
            report_mismatch("overflow", DATA_W'(sorted.overflow),
                            DATA_W'(want.overflow));
        end
      end
      if (elements.valid && elements.ready) begin
        if (fill_count < MAX_ELEMS) begin
          set_buf[fill_count] = elements.value;
          fill_count++;
        end else begin
          set_dropped = 1'b1;
        end
        if (elements.last) begin
          // merge passes of run width 1, 2, 4, ..., left run wins ties
          for (w = 1; w < fill_count; w = w * 2) begin
            for (lo = 0; lo < fill_count; lo = lo + 2 * w) begin
              mid = (lo + w > fill_count) ? fill_count : lo + w;
              hi  = (lo + 2 * w > fill_count) ? fill_count : lo + 2 * w;
              i   = lo;
              j   = mid;
              for (k = lo; k < hi; k++) begin
                if (i < mid && (j >= hi || set_buf[i] <= set_buf[j])) begin
                  merge_buf[k] = set_buf[i];
                  i++;
                end else begin
                  merge_buf[k] = set_buf[j];
                  j++;
                end
              end
            end
            for (k = 0; k < fill_count; k++) set_buf[k] = merge_buf[k];
          end
          for (k = 0; k < fill_count; k++) begin
            want.value      = set_buf[k];
            want.end_of_set = (k == fill_count - 1);
            want.overflow   = set_dropped;
            sorted_due.push_back(want);
          end
          fill_count  = 0;
          set_dropped = 1'b0;
        end
      end
    end
    results_due = sorted_due.size();
  end

endmodule

// File: dv/merge_sorter_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// merge_sorter_top_tb
// drives sets of signed elements into the merge sorter, from single elements
// and extreme values to full and overflowing sets, under changing sender
// gaps and receiver stalls; a checker beside the block predicts and compares
// ----------------------------------------------------------------------------
module merge_sorter_top_tb;
  import ms_pkg::*;

  localparam int IDLE_LIMIT   = 4000;
  localparam int RANDOM_ITEMS = 330;
  localparam int DRAIN_CYCLES = 16;

  localparam data_t MIN_VAL = 32'sh8000_0000;
  localparam data_t MAX_VAL = 32'sh7fff_ffff;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ms_in_if  elements();
  ms_out_if sorted();

  int mismatches;
  int results_due;
  int src_idle_pct;
  int sink_stall_pct;
  int set_idx;
  int idle_cycles;

  merge_sorter_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .elements (elements),
    .sorted   (sorted)
  );

  merge_sorter_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .elements    (elements),
    .sorted      (sorted),
    .mismatches  (mismatches),
    .results_due (results_due)
  );

  always #6 clk = ~clk;

  always @(negedge clk) begin
    sorted.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // watchdog: cycles without any transfer
  always @(posedge clk) begin
    if (rst || (elements.valid && elements.ready) || (sorted.valid && sorted.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // rotate idling per set: none, sender gaps, receiver stalls, both
  task automatic next_set;
    case (set_idx % 4)
      0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      1: begin src_idle_pct = 69; sink_stall_pct = 0;  end
      2: begin src_idle_pct = 0;  sink_stall_pct = 69; end
      default: begin src_idle_pct = 37; sink_stall_pct = 37; end
    endcase
    set_idx++;
  endtask

  task automatic push_element(data_t v, logic l);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      elements.valid <= 1'b0;
      @(negedge clk);
    end
    elements.valid <= 1'b1;
    elements.value <= v;
    elements.last  <= l;
    @(posedge clk);
    while (!elements.ready) @(posedge clk);
  endtask

  initial begin
    int    sent, n, mode, pick;
    data_t v;
    elements.valid = 1'b0;
    elements.value = '0;
    elements.last  = 1'b0;
    sorted.ready   = 1'b0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    set_idx        = 0;
    idle_cycles    = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // single-element sets at both extremes
    next_set();
    push_element(MIN_VAL, 1'b1);
    next_set();
    push_element(MAX_VAL, 1'b1);
    // two elements in reverse order
    next_set();
    push_element(MAX_VAL, 1'b0);
    push_element(MIN_VAL, 1'b1);
    // equal values and a small odd set
    next_set();
    push_element(32'sd5, 1'b0);
    push_element(-32'sd5, 1'b0);
    push_element(32'sd5, 1'b1);
    next_set();
    push_element(32'sd0, 1'b0);
    push_element(-32'sd1, 1'b0);
    push_element(32'sd1, 1'b1);
    // extremes mixed with duplicates
    next_set();
    push_element(MIN_VAL, 1'b0);
    push_element(MAX_VAL, 1'b0);
    push_element(32'sd0, 1'b0);
    push_element(-32'sd1, 1'b0);
    push_element(32'sd1, 1'b0);
    push_element(MIN_VAL, 1'b0);
    push_element(MAX_VAL, 1'b1);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case (set_idx)
        8:  n = MAX_ELEMS;
        11: n = MAX_ELEMS + 1;
        15: n = MAX_ELEMS + $urandom_range(2, 6);
        default: n = ($urandom_range(24) == 0) ? MAX_ELEMS : $urandom_range(1, 12);
      endcase
      mode = $urandom_range(3);
      next_set();
      for (int e = 0; e < n; e++) begin
        case (mode)
          2: v = data_t'($urandom_range(7)) - 32'sd4;
          3: begin
            pick = $urandom_range(4);
            case (pick)
              0: v = MIN_VAL;
              1: v = MAX_VAL;
              2: v = 32'sd0;
              3: v = -32'sd1;
              default: v = data_t'($urandom);
            endcase
          end
          default: v = data_t'($urandom);
        endcase
        push_element(v, e == n - 1);
        sent++;
      end
    end

    @(negedge clk);
    elements.valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
